// ===== sv/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FIFO_D  = 4;
  localparam int unsigned FPTR_W  = $clog2(FIFO_D);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REVERSE    = 3'd4,
    KIND_REPORT     = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [VAL_W-1:0]  front_value;
    logic [VAL_W-1:0]  back_value;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

// ===== sv/double_ended_queue.sv =====
// channel  | handshake                    | payload
// request  | in_valid_i / in_stall_o      | kind_i, value_i
// result   | out_valid_o / out_stall_i    | front_value_o, back_value_o, entry_count_o,
//          |                              | is_empty_o, status_o
// one request per cycle unless in_stall_o; result registered in core, then output FIFO
// the ring store is written and read in the accept cycle, read data registered
// reset clears pointers, count, direction and queues; store contents stay undefined
// up to three requests in flight; in_stall_o rises only when the result side stalls
module double_ended_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [deq_pkg::KIND_W-1:0] kind_i,
  input  logic [deq_pkg::VAL_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [deq_pkg::VAL_W-1:0]  front_value_o,
  output logic [deq_pkg::VAL_W-1:0]  back_value_o,
  output logic [deq_pkg::CNT_W-1:0]  entry_count_o,
  output logic                       is_empty_o,
  output logic [deq_pkg::STAT_W-1:0] status_o
);
  import deq_pkg::*;

  logic       in_acc, out_acc, res_valid;
  logic [1:0] occ_q;
  res_t       res, out_res;

  assign in_stall_o = (occ_q == 2'd3);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  deq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_acc_i   (in_acc),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  deq_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .data_o  (out_res)
  );

  assign front_value_o = out_res.front_value;
  assign back_value_o  = out_res.back_value;
  assign entry_count_o = out_res.entry_count;
  assign is_empty_o    = out_res.is_empty;
  assign status_o      = out_res.status;

  a_out_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != 2'd0))
    else $error("result without outstanding request");

endmodule

// ===== sv/deq_core.sv =====
module deq_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_acc_i,
  input  logic [deq_pkg::KIND_W-1:0] kind_i,
  input  logic [deq_pkg::VAL_W-1:0]  value_i,
  output logic                       res_valid_o,
  output deq_pkg::res_t              res_o
);
  import deq_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rev_q, rev_d;
  logic              vld_q;
  logic [STAT_W-1:0] status_q;
  status_e           status_d;
  logic [VAL_W-1:0]  rd0_q, rd1_q, val_q;
  logic              fwd0_q, fwd1_q;

  logic              is_push, is_pop, at_first, full, empty, we;
  logic [IDX_W-1:0]  wr_addr, rd0_addr, rd1_addr;
  logic [VAL_W-1:0]  first_val, last_val;
  kind_e             kind;

  assign kind  = kind_e'(kind_i);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    unique case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: is_push = 1'b1;
      KIND_POP_FRONT, KIND_POP_BACK:   is_pop  = 1'b1;
      default: ;
    endcase
  end

  // front kinds have bit 0 clear; a reversed deque swaps the ends
  assign at_first = (kind_i[0] == 1'b0) != rev_q;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = ST_DONE;
    we       = 1'b0;
    wr_addr  = head_q + count_q[IDX_W-1:0];
    if (is_push) begin
      if (full) begin
        status_d = ST_PUSH_FULL;
      end else begin
        we      = 1'b1;
        count_d = count_q + 1'b1;
        if (at_first) begin
          head_d  = head_q - 1'b1;
          wr_addr = head_q - 1'b1;
        end
      end
    end else if (is_pop) begin
      if (empty) begin
        status_d = ST_POP_EMPTY;
      end else begin
        count_d = count_q - 1'b1;
        if (at_first) begin
          head_d = head_q + 1'b1;
        end
      end
    end else if (kind == KIND_REVERSE) begin
      rev_d = ~rev_q;
    end
  end

  assign rd0_addr = head_d;
  assign rd1_addr = head_d + count_d[IDX_W-1:0] - 1'b1;

  always_ff @(posedge clk_i) begin
    if (req_acc_i && we) begin
      mem[wr_addr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc_i) begin
      rd0_q    <= mem[rd0_addr];
      rd1_q    <= mem[rd1_addr];
      fwd0_q   <= we && (wr_addr == rd0_addr);
      fwd1_q   <= we && (wr_addr == rd1_addr);
      val_q    <= value_i;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= req_acc_i;
      if (req_acc_i) begin
        head_q  <= head_d;
        count_q <= count_d;
        rev_q   <= rev_d;
      end
    end
  end

  // write forwarding for an entry pushed by the same request
  assign first_val = empty ? '0 : (fwd0_q ? val_q : rd0_q);
  assign last_val  = empty ? '0 : (fwd1_q ? val_q : rd1_q);

  assign res_valid_o       = vld_q;
  assign res_o.front_value = rev_q ? last_val : first_val;
  assign res_o.back_value  = rev_q ? first_val : last_val;
  assign res_o.entry_count = count_q;
  assign res_o.is_empty    = empty;
  assign res_o.status      = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc_i && status_d != ST_DONE) |=> ($stable(head_q) && $stable(count_q)))
    else $error("rejected request changed the deque");

  a_reject_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc_i && is_push && full) |=> (status_q == ST_PUSH_FULL))
    else $error("push on full not flagged");

endmodule

// ===== sv/deq_out_fifo.sv =====
module deq_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  deq_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          pop_i,
  output deq_pkg::res_t data_o
);
  import deq_pkg::*;

  res_t              buf_q [FIFO_D];
  logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FPTR_W:0]   cnt_q;
  logic              do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (FPTR_W+1)'(push_i) - (FPTR_W+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !do_pop && cnt_q == (FPTR_W+1)'(FIFO_D)))
    else $error("output queue overflow");

endmodule

// ===== test/tb_double_ended_queue.sv =====
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i;
  logic [VAL_W-1:0]  value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [VAL_W-1:0]  front_value_o;
  logic [VAL_W-1:0]  back_value_o;
  logic [CNT_W-1:0]  entry_count_o;
  logic              is_empty_o;
  logic [STAT_W-1:0] status_o;

  // model of the deque contents
  logic [VAL_W-1:0] deque_store [DEPTH];
  int unsigned      deque_head;
  int unsigned      deque_count;
  logic             deque_flipped;

  res_t        pending_results [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  double_ended_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic res_t predict_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value);
    res_t             r;
    status_e          st;
    logic             at_front;
    logic [VAL_W-1:0] first_v;
    logic [VAL_W-1:0] last_v;
    st      = ST_DONE;
    first_v = '0;
    last_v  = '0;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          st = ST_PUSH_FULL;
        end else begin
          at_front = (kind == KIND_PUSH_FRONT);
          if (at_front != deque_flipped) begin
            deque_head = (deque_head + DEPTH - 1) % DEPTH;
            deque_store[deque_head] = value;
          end else begin
            deque_store[(deque_head + deque_count) % DEPTH] = value;
          end
          deque_count++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (deque_count == 0) begin
          st = ST_POP_EMPTY;
        end else begin
          at_front = (kind == KIND_POP_FRONT);
          if (at_front != deque_flipped) begin
            deque_head = (deque_head + 1) % DEPTH;
          end
          deque_count--;
        end
      end
      KIND_REVERSE: begin
        deque_flipped = ~deque_flipped;
      end
      default: ;
    endcase
    if (deque_count != 0) begin
      first_v = deque_store[deque_head];
      last_v  = deque_store[(deque_head + deque_count - 1) % DEPTH];
    end
    r.front_value = deque_flipped ? last_v : first_v;
    r.back_value  = deque_flipped ? first_v : last_v;
    r.entry_count = CNT_W'(deque_count);
    r.is_empty    = (deque_count == 0);
    r.status      = st;
    return r;
  endfunction

  // called right after a rising edge
  task automatic send_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_request(kind, value));
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_W'($urandom);
      value_i    <= {$urandom, $urandom};
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual front %h back %h count %0d",
                 $time, front_value_o, back_value_o, entry_count_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("front_value", want.front_value, front_value_o);
        check_field("back_value", want.back_value, back_value_o);
        check_field("entry_count", VAL_W'(want.entry_count), VAL_W'(entry_count_o));
        check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(is_empty_o));
        check_field("status", VAL_W'(want.status), VAL_W'(status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_empty_deque();
    send_request(KIND_POP_FRONT, '1);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_REVERSE, 64'h0123_4567_89ab_cdef);
    send_request(KIND_REVERSE, '0);
    send_request(KIND_REPORT, '0);
    send_request(3'd6, '1);
    send_request(3'd7, '0);
  endtask

  task automatic test_fill_and_overflow();
    logic [VAL_W-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: v = '0;
        1: v = '1;
        2: v = {32{2'b10}};
        default: v = {$urandom, $urandom};
      endcase
      send_request((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, v);
    end
    send_request(KIND_PUSH_FRONT, {32{2'b01}});
    send_request(KIND_PUSH_BACK, '1);
  endtask

  task automatic test_reverse_and_pop();
    send_request(KIND_REVERSE, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_POP_BACK, '0);
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned       push_bias;
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    push_bias          = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      // bursts that lean toward filling or draining
      if (i % 24 == 0) push_bias = $urandom_range(15, 85);
      pick = $urandom_range(99);
      if (pick < 6) begin
        kind = KIND_REVERSE;
      end else if (pick < 10) begin
        kind = KIND_W'($urandom_range(KIND_REPORT, 7));
      end else if ($urandom_range(99) < push_bias) begin
        kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end else begin
        kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end
      case ($urandom_range(7))
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      send_request(kind, value);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    kind_i             <= '0;
    value_i            <= '0;
    out_stall_i        <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatches         = 0;
    cycle_count        = 0;
    deque_head         = 0;
    deque_count        = 0;
    deque_flipped      = 1'b0;
    for (int i = 0; i < DEPTH; i++) deque_store[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_deque();
    test_fill_and_overflow();
    test_reverse_and_pop();
    test_random_traffic(490, 0, 0);
    test_random_traffic(490, 51, 0);
    test_random_traffic(490, 0, 51);
    test_random_traffic(490, 23, 23);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
